>>> hw/rtl/kdit_pkg.sv
`default_nettype none

package kdit_pkg;

    localparam int CAPACITY  = 64;
    localparam int KEY_W     = 64;
    localparam int GEN_W     = 32;
    localparam int OUT_IDX_W = 6;
    localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int KIND_W    = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT  = 2'd0,
        KIND_RESOLVE = 2'd1,
        KIND_REBUILD = 2'd2
    } kind_t;

    // Packed low to high: index, found, full_res, generation.
    typedef struct packed {
        logic [GEN_W-1:0]     generation;
        logic                 full_res;
        logic                 found;
        logic [OUT_IDX_W-1:0] index;
    } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/kdit_ram.sv
`default_nettype none

module kdit_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire                                           clk,
    input  wire                                           wr_en,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   wr_addr,
    input  wire [WIDTH-1:0]                               wr_data,
    input  wire                                           rd_en,
    input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/key_to_dense_index_table_unit.sv
`default_nettype none

// Key interning table: an insert returns the dense index a 64-bit key already holds, or stores
// the key at the next free slot (equal to the entry count) and returns that slot; a resolve
// reports presence and index; a rebuild empties the table and bumps a 32-bit generation that
// skips zero on wrap. An insert of a new key into a full table stores nothing and flags full.
// Keys live in a single-port-read memory, and one 64-bit comparator walks the stored entries
// one per cycle, so an insert or resolve keeps the input side busy while it walks all N stored
// entries, N being the entry count, less on an early hit; rebuild and unused kinds go straight
// to the post state. One item is in flight at a time; the result sits in an output register,
// so a stalled output does not block the next accept; that item then waits in ST_POST.
module key_to_dense_index_table_unit (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire  [kdit_pkg::KEY_W-1:0]            s_axis_tdata,  // key
    input  wire  [kdit_pkg::KIND_W-1:0]           s_axis_tuser,  // kind
    output logic                                  m_axis_tvalid,
    input  wire                                   m_axis_tready,
    output logic [$bits(kdit_pkg::result_t)-1:0]  m_axis_tdata   // index, found, full_res, generation
);

    import kdit_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_POST
    } state_t;

    state_t             state_reg, state_next;
    kind_t              kind_reg, kind_next;
    logic [KEY_W-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [GEN_W-1:0]   gen_reg, gen_next;
    logic [CNT_W-1:0]   scan_ptr_reg, scan_ptr_next;
    logic               cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    logic               found_reg, found_next;
    logic               full_reg, full_next;
    logic               m_valid_reg, m_valid_next;
    result_t            out_reg, out_next;

    logic               rd_en;
    logic               wr_en;
    logic [KEY_W-1:0]   rd_data;
    logic               hit;
    logic               more;
    logic [IDX_W+OUT_IDX_W-1:0] pos_wide;

    kdit_ram #(
        .WIDTH (KEY_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_W-1:0]),
        .wr_data (key_reg),
        .rd_en   (rd_en),
        .rd_addr (scan_ptr_reg[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    assign hit           = cmp_valid_reg && (rd_data == key_reg);
    assign more          = scan_ptr_reg < count_reg;
    assign pos_wide      = (IDX_W + OUT_IDX_W)'(pos_reg);
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        key_next       = key_reg;
        count_next     = count_reg;
        gen_next       = gen_reg;
        scan_ptr_next  = scan_ptr_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        full_next      = full_reg;
        m_valid_next   = m_valid_reg;
        out_next       = out_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    kind_next      = kind_t'(s_axis_tuser);
                    key_next       = s_axis_tdata;
                    scan_ptr_next  = '0;
                    cmp_valid_next = 1'b0;
                    pos_next       = '0;
                    found_next     = 1'b0;
                    full_next      = 1'b0;
                    case (kind_t'(s_axis_tuser))
                        KIND_INSERT, KIND_RESOLVE:
                        begin
                            state_next = ST_SCAN;
                        end
                        KIND_REBUILD:
                        begin
                            count_next = '0;
                            // skip zero on wrap
                            gen_next   = (gen_reg == '1) ? GEN_W'(1) : gen_reg + GEN_W'(1);
                            state_next = ST_POST;
                        end
                        default:
                        begin
                            state_next = ST_POST;
                        end
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    pos_next       = cmp_idx_reg;
                    found_next     = 1'b1;
                    cmp_valid_next = 1'b0;
                    state_next     = ST_POST;
                end
                else if (!more)
                begin
                    // every stored entry compared without a match
                    cmp_valid_next = 1'b0;
                    state_next     = ST_POST;
                    if (kind_reg == KIND_INSERT)
                    begin
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            wr_en      = 1'b1;
                            pos_next   = count_reg[IDX_W-1:0];
                            found_next = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                else
                begin
                    rd_en          = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_ptr_reg[IDX_W-1:0];
                    scan_ptr_next  = scan_ptr_reg + CNT_W'(1);
                end
            end

            ST_POST:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next        = 1'b1;
                    out_next.index      = pos_wide[OUT_IDX_W-1:0];
                    out_next.found      = found_reg;
                    out_next.full_res   = full_reg;
                    out_next.generation = gen_reg;
                    state_next          = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_INSERT;
            key_reg       <= '0;
            count_reg     <= '0;
            gen_reg       <= '0;
            scan_ptr_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            cmp_idx_reg   <= '0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            full_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            key_reg       <= key_next;
            count_reg     <= count_next;
            gen_reg       <= gen_next;
            scan_ptr_reg  <= scan_ptr_next;
            cmp_valid_reg <= cmp_valid_next;
            cmp_idx_reg   <= cmp_idx_next;
            pos_reg       <= pos_next;
            found_reg     <= found_next;
            full_reg      <= full_next;
            m_valid_reg   <= m_valid_next;
            out_reg       <= out_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_REBUILD) |=> gen_reg != '0)
        else $error("generation zero after rebuild");

    a_cmp_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && cmp_valid_reg) |-> CNT_W'(cmp_idx_reg) < count_reg)
        else $error("compare slot beyond stored entries");

    a_found_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> !(out_reg.found && out_reg.full_res))
        else $error("found and full both set");
`endif

endmodule

`default_nettype wire

>>> tb/key_to_dense_index_table_unit_tb.sv
`timescale 1ns / 1ps

module key_to_dense_index_table_unit_tb;
    import kdit_pkg::*;

    localparam int          CYCLE_LIMIT  = 2_000_000;
    localparam int          ITEM_TARGET  = 1700;
    localparam int          DRAIN_CYCLES = 100;
    localparam logic [1:0]  KIND_UNUSED  = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
    } request_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [KEY_W-1:0]            s_axis_tdata = '0;  // key
    logic [KIND_W-1:0]           s_axis_tuser = '0;  // kind
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [$bits(result_t)-1:0]  m_axis_tdata;       // index, found, full_res, generation

    key_to_dense_index_table_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    request_t         pending_items[$];
    result_t          expected_results[$];

    // Shadow copy of the table
    logic [KEY_W-1:0] shadow_keys [CAPACITY];
    int               shadow_count = 0;
    logic [GEN_W-1:0] shadow_gen = '0;

    int               mismatch_count = 0;
    int               cycle_count = 0;
    int               send_gap = 0;
    int               recv_stall = 0;
    bit               send_burst = 1'b0;
    bit               recv_burst = 1'b0;

    function automatic result_t intern_request(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key);
        result_t r;
        int      pos;
        bit      hit;
        r   = '0;
        pos = 0;
        hit = 1'b0;
        if (kind == KIND_INSERT || kind == KIND_RESOLVE)
        begin
            for (int i = 0; i < shadow_count; i++)
            begin
                if (!hit && shadow_keys[i] == key)
                begin
                    hit = 1'b1;
                    pos = i;
                end
            end
        end
        case (kind)
            KIND_INSERT:
            begin
                if (hit)
                    r.found = 1'b1;
                else if (shadow_count < CAPACITY)
                begin
                    pos = shadow_count;
                    shadow_keys[pos] = key;
                    shadow_count++;
                    r.found = 1'b1;
                end
                else
                    r.full_res = 1'b1;
            end
            KIND_RESOLVE:
                r.found = hit;
            KIND_REBUILD:
            begin
                shadow_count = 0;
                shadow_gen   = shadow_gen + GEN_W'(1);
                if (shadow_gen == '0)
                    shadow_gen = GEN_W'(1);
            end
            default: ;
        endcase
        r.index      = pos[OUT_IDX_W-1:0];
        r.generation = shadow_gen;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one, none at all in burst stretches
    function automatic int pick_idle(bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 60)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 70);
    endfunction

    function automatic request_t make_item(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key);
        request_t q;
        q.kind = kind;
        q.key  = key;
        return q;
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // Driver: present queued items, predict on accept
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_results.push_back(intern_request(s_axis_tuser, s_axis_tdata));
                if ($urandom_range(0, 199) == 0)
                    send_burst = ~send_burst;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap      = send_gap - 1;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pending_items.size() > 0)
                begin
                    request_t nxt;
                    nxt = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.key;
                    s_axis_tuser  <= nxt.kind;
                    send_gap      = pick_idle(send_burst);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: random backpressure, compare each item with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_t got;
                result_t want;
                got = result_t'(m_axis_tdata);
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: index %0d found %0d full %0d gen %h",
                                 got.index, got.found, got.full_res, got.generation);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.index != want.index || got.found != want.found ||
                        got.full_res != want.full_res || got.generation != want.generation)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("mismatch: expected index %0d found %0d full %0d gen %h",
                                     want.index, want.found, want.full_res, want.generation);
                            $display("          got index %0d found %0d full %0d gen %h",
                                     got.index, got.found, got.full_res, got.generation);
                        end
                    end
                end
                if ($urandom_range(0, 199) == 0)
                    recv_burst = ~recv_burst;
            end
            if (recv_stall > 0)
            begin
                recv_stall    = recv_stall - 1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                recv_stall    = pick_idle(recv_burst);
                m_axis_tready <= (recv_stall == 0);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        logic [KEY_W-1:0] pool[$];
        int               pool_size;
        int               cursor;
        int               r;
        logic [KEY_W-1:0] k;

        // Directed: key extremes, duplicates, misses, unused kind, rebuild
        pending_items.push_back(make_item(KIND_INSERT, '0));
        pending_items.push_back(make_item(KIND_INSERT, '1));
        pending_items.push_back(make_item(KIND_INSERT, '0));
        pending_items.push_back(make_item(KIND_RESOLVE, '1));
        pending_items.push_back(make_item(KIND_RESOLVE, '0));
        pending_items.push_back(make_item(KIND_RESOLVE, 64'h5555_5555_5555_5555));
        pending_items.push_back(make_item(KIND_RESOLVE, 64'hAAAA_AAAA_AAAA_AAAA));
        pending_items.push_back(make_item(KIND_INSERT, 64'h8000_0000_0000_0001));
        pending_items.push_back(make_item(KIND_RESOLVE, 64'h8000_0000_0000_0000));
        pending_items.push_back(make_item(KIND_RESOLVE, 64'h8000_0000_0000_0001));
        pending_items.push_back(make_item(KIND_UNUSED, '1));
        pending_items.push_back(make_item(KIND_INSERT, '1));
        pending_items.push_back(make_item(KIND_REBUILD, random_key()));
        pending_items.push_back(make_item(KIND_RESOLVE, '1));
        pending_items.push_back(make_item(KIND_INSERT, '1));
        pending_items.push_back(make_item(KIND_RESOLVE, '1));
        pending_items.push_back(make_item(KIND_UNUSED, '0));
        pending_items.push_back(make_item(KIND_REBUILD, '1));
        pending_items.push_back(make_item(KIND_REBUILD, '0));
        pending_items.push_back(make_item(KIND_RESOLVE, '0));

        // Random phases: fill a table from a key pool, some phases past full, then rebuild
        while (pending_items.size() < ITEM_TARGET)
        begin
            pool.delete();
            if ($urandom_range(0, 3) == 0)
                pool_size = CAPACITY + $urandom_range(1, 8);
            else
                pool_size = $urandom_range(1, 24);
            for (int i = 0; i < pool_size; i++)
                pool.push_back(random_key());
            cursor = 0;
            while (cursor < pool_size || $urandom_range(0, 5) != 0)
            begin
                r = $urandom_range(0, 99);
                if (r < 55 && cursor < pool_size)
                begin
                    pending_items.push_back(make_item(KIND_INSERT, pool[cursor]));
                    cursor++;
                end
                else if (r < 70 && cursor > 0)
                    pending_items.push_back(make_item(KIND_INSERT,
                                            pool[$urandom_range(0, cursor - 1)]));
                else if (r < 85)
                    pending_items.push_back(make_item(KIND_RESOLVE,
                                            pool[$urandom_range(0, pool_size - 1)]));
                else if (r < 92)
                begin
                    // near miss: one bit away from a pooled key
                    k = pool[$urandom_range(0, pool_size - 1)] ^ (64'd1 << $urandom_range(0, 63));
                    pending_items.push_back(make_item($urandom_range(0, 1) ? KIND_RESOLVE
                                                                           : KIND_INSERT, k));
                end
                else if (r < 96)
                    pending_items.push_back(make_item(KIND_UNUSED, random_key()));
                else if (r < 98)
                    pending_items.push_back(make_item(KIND_INSERT, random_key()));
                else
                    pending_items.push_back(make_item(KIND_REBUILD, random_key()));
            end
            pending_items.push_back(make_item(KIND_REBUILD, random_key()));
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_items.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        while (expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
